>>> hw/rtl/salcp_pkg.sv
// Shared types and constants for the suffix array and LCP builder.
// Holds the fixed field widths, the sequencer step codes and the
// command and status bundles between controller and datapath.
package salcp_pkg;

    // Field widths of the item ports
    localparam int CODE_W = 5;
    localparam int RANK_W = 11;
    localparam int SS_W   = 11;
    localparam int LP_W   = 10;

    typedef logic [5:0] t_step;

    // Sequencer steps
    localparam t_step ST_IDLE     = 6'd0;
    localparam t_step ST_RD_ISSUE = 6'd1;
    localparam t_step ST_RD_OUT   = 6'd2;
    localparam t_step ST_INIT_RD  = 6'd3;
    localparam t_step ST_INIT_WR  = 6'd4;
    localparam t_step ST_CS_CLR   = 6'd5;
    localparam t_step ST_CS_CNT_A = 6'd6;
    localparam t_step ST_CS_CNT_B = 6'd7;
    localparam t_step ST_CS_CNT_C = 6'd8;
    localparam t_step ST_CS_PRE_A = 6'd9;
    localparam t_step ST_CS_PRE_B = 6'd10;
    localparam t_step ST_CS_PL_A  = 6'd11;
    localparam t_step ST_CS_PL_B  = 6'd12;
    localparam t_step ST_CS_PL_C  = 6'd13;
    localparam t_step ST_CS_PL_D  = 6'd14;
    localparam t_step ST_D_START  = 6'd15;
    localparam t_step ST_D_CHECK  = 6'd16;
    localparam t_step ST_D_FILL1  = 6'd17;
    localparam t_step ST_D_FILL2A = 6'd18;
    localparam t_step ST_D_FILL2B = 6'd19;
    localparam t_step ST_D_COPY_A = 6'd20;
    localparam t_step ST_D_COPY_B = 6'd21;
    localparam t_step ST_D_RR_A   = 6'd22;
    localparam t_step ST_D_RR_B   = 6'd23;
    localparam t_step ST_D_RR_C   = 6'd24;
    localparam t_step ST_D_RR_D   = 6'd25;
    localparam t_step ST_FIN_A    = 6'd26;
    localparam t_step ST_FIN_B    = 6'd27;
    localparam t_step ST_LCP_A    = 6'd28;
    localparam t_step ST_LCP_B    = 6'd29;
    localparam t_step ST_LCP_C    = 6'd30;
    localparam t_step ST_LCP_E    = 6'd31;
    localparam t_step ST_LCP_F    = 6'd32;
    localparam t_step ST_DONE     = 6'd33;

    typedef struct packed {
        t_step step;
        logic  idle;
        logic  accept;
    } t_cmd;

    typedef struct packed {
        logic in_read;
        logic in_last;
        logic rd_err;
        logic eq_n;
        logic eq_m;
        logic eq_w;
        logic i_one;
        logic go_on;
        logic le1;
        logic match;
        logic out_free;
    } t_stat;

endpackage

>>> hw/rtl/salcp_ctrl.sv
// Sequencer for the suffix array and LCP builder.
// Depends on salcp_pkg; drives step commands into salcp_dp.
module salcp_ctrl
    import salcp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_step r_state, n_state;
    logic  r_loop, n_loop;

    assign o_cmd.step   = r_state;
    assign o_cmd.idle   = (r_state == ST_IDLE);
    assign o_cmd.accept = (r_state == ST_IDLE) && i_valid;

    always_comb begin
        n_state = r_state;
        n_loop  = r_loop;
        unique case (r_state)
            ST_IDLE: begin
                n_loop = 1'b0;
                if (i_valid) begin
                    if (i_stat.in_read) begin
                        n_state = i_stat.rd_err ? ST_RD_OUT : ST_RD_ISSUE;
                    end else if (i_stat.in_last) begin
                        n_state = ST_INIT_RD;
                    end
                end
            end
            ST_RD_ISSUE: n_state = ST_RD_OUT;
            ST_RD_OUT:   if (i_stat.out_free) n_state = ST_IDLE;
            ST_INIT_RD:  n_state = ST_INIT_WR;
            ST_INIT_WR:  n_state = i_stat.eq_n ? ST_CS_CLR : ST_INIT_RD;
            ST_CS_CLR:   if (i_stat.eq_m) n_state = ST_CS_CNT_A;
            ST_CS_CNT_A: n_state = ST_CS_CNT_B;
            ST_CS_CNT_B: n_state = ST_CS_CNT_C;
            ST_CS_CNT_C: n_state = i_stat.eq_n ? ST_CS_PRE_A : ST_CS_CNT_A;
            ST_CS_PRE_A: n_state = ST_CS_PRE_B;
            ST_CS_PRE_B: n_state = i_stat.eq_m ? ST_CS_PL_A : ST_CS_PRE_A;
            ST_CS_PL_A:  n_state = ST_CS_PL_B;
            ST_CS_PL_B:  n_state = ST_CS_PL_C;
            ST_CS_PL_C:  n_state = ST_CS_PL_D;
            ST_CS_PL_D: begin
                if (i_stat.i_one) n_state = r_loop ? ST_D_COPY_A : ST_D_START;
                else n_state = ST_CS_PL_A;
            end
            ST_D_START:  n_state = ST_D_CHECK;
            ST_D_CHECK:  n_state = i_stat.go_on ? ST_D_FILL1 : ST_FIN_A;
            ST_D_FILL1:  if (i_stat.eq_w) n_state = ST_D_FILL2A;
            ST_D_FILL2A: n_state = ST_D_FILL2B;
            ST_D_FILL2B: begin
                if (i_stat.eq_n) begin
                    n_state = ST_CS_CLR;
                    n_loop  = 1'b1;
                end else begin
                    n_state = ST_D_FILL2A;
                end
            end
            ST_D_COPY_A: n_state = ST_D_COPY_B;
            ST_D_COPY_B: n_state = i_stat.eq_n ? ST_D_RR_A : ST_D_COPY_A;
            ST_D_RR_A:   n_state = ST_D_RR_B;
            ST_D_RR_B:   n_state = ST_D_RR_C;
            ST_D_RR_C:   n_state = ST_D_RR_D;
            ST_D_RR_D:   n_state = i_stat.eq_n ? ST_D_CHECK : ST_D_RR_A;
            ST_FIN_A:    n_state = ST_FIN_B;
            ST_FIN_B:    n_state = i_stat.eq_n ? ST_LCP_A : ST_FIN_A;
            ST_LCP_A:    n_state = ST_LCP_B;
            ST_LCP_B: begin
                if (!i_stat.le1) n_state = ST_LCP_C;
                else n_state = i_stat.eq_n ? ST_DONE : ST_LCP_A;
            end
            ST_LCP_C:    n_state = ST_LCP_E;
            ST_LCP_E:    n_state = ST_LCP_F;
            ST_LCP_F: begin
                if (i_stat.match) n_state = ST_LCP_E;
                else n_state = i_stat.eq_n ? ST_DONE : ST_LCP_A;
            end
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_loop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_loop  <= n_loop;
        end
    end

endmodule

>>> hw/rtl/salcp_dp.sv
// Datapath of the suffix array and LCP builder: text, order, rank,
// scratch, bucket and LCP memories, loop counters and the result register.
// Depends on salcp_pkg; steered by salcp_ctrl.
module salcp_dp
    import salcp_pkg::*;
#(
    parameter int MAX_LEN  = 1024,
    parameter int ALPHABET = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd_bus,
    output t_stat             o_stat,
    input  logic              i_cmd,
    input  logic [CODE_W-1:0] i_char_code,
    input  logic              i_last_char,
    input  logic [RANK_W-1:0] i_rank_index,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [SS_W-1:0]   o_suffix_start,
    output logic [LP_W-1:0]   o_lcp_prev,
    output logic              o_status
);

    localparam int CMAX = (MAX_LEN > ALPHABET) ? MAX_LEN : ALPHABET;
    localparam int AW   = $clog2(MAX_LEN + 1);
    localparam int VW   = $clog2(CMAX + 1);
    localparam int WW   = VW + 1;
    localparam int LW   = $clog2(ALPHABET);
    localparam int TD   = MAX_LEN + 1;
    localparam int CD   = CMAX + 1;

    logic [LW-1:0] m_txt [0:TD-1];
    logic [AW-1:0] m_sa  [0:TD-1];
    logic [VW-1:0] m_rk  [0:TD-1];
    logic [VW-1:0] m_tmp [0:TD-1];
    logic [VW-1:0] m_cnt [0:CD-1];
    logic [AW-1:0] m_lcp [0:TD-1];

    logic [LW-1:0] r_txt0, r_txt1;
    logic [AW-1:0] r_sa, r_lcp;
    logic [VW-1:0] r_rk, r_tmp, r_cnt;

    logic [AW-1:0] r_n, r_pos, r_j, r_r, r_k, r_rank;
    logic [VW-1:0] r_i, r_m, r_p, r_q, r_key, r_sum, r_ka, r_pa, r_pb;
    logic [WW-1:0] r_w;
    logic          r_built, r_inr, r_err, r_ovalid, r_st;
    logic [SS_W-1:0] r_ss;
    logic [LP_W-1:0] r_lp;

    // Port controls
    logic          txt_we;
    logic [AW-1:0] txt_wa, txt_ra0, txt_ra1;
    logic [LW-1:0] txt_wd;
    logic          sa_we, rk_we, tmp_we, cnt_we, lcp_we;
    logic [AW-1:0] sa_wa, sa_wd, sa_ra, rk_wa, rk_ra, tmp_wa, tmp_ra, lcp_wa, lcp_wd;
    logic [VW-1:0] rk_wd, tmp_wd, cnt_wa, cnt_wd, cnt_ra;

    logic [AW-1:0] i_a;
    logic [VW-1:0] n_v, kb, p_new;
    logic [WW-1:0] i_w, n_w, pw, ij, kj;
    logic [LW-1:0] code_c;
    logic          load, is_load, same, inr, sa_gt, rd_err, out_free;

    assign i_a = r_i[AW-1:0];
    assign n_v = VW'(r_n);
    assign i_w = WW'(r_i);
    assign n_w = WW'(r_n);
    assign pw  = WW'(r_pos) + r_w;
    assign ij  = i_w + WW'(r_j);
    assign kj  = WW'(r_k) + WW'(r_j);
    assign inr = (ij <= n_w) && (kj <= n_w);
    assign kb  = (pw <= n_w) ? r_tmp : '0;
    assign same  = (r_ka == r_pa) && (kb == r_pb);
    assign p_new = (r_i == VW'(1)) ? VW'(1) : (same ? r_p : r_p + VW'(1));
    assign sa_gt = WW'(r_sa) > r_w;
    assign code_c = (32'(i_char_code) >= ALPHABET) ? LW'(ALPHABET - 1) : LW'(i_char_code);
    assign rd_err = !r_built || (i_rank_index == '0) || (32'(i_rank_index) > 32'(r_n));
    assign out_free = !r_ovalid || !i_stall;
    assign is_load  = i_cmd_bus.accept && !i_cmd;
    assign load     = is_load && (r_built || (32'(r_n) < MAX_LEN));

    assign txt_we = load;
    assign txt_wa = r_built ? AW'(1) : r_n + AW'(1);
    assign txt_wd = code_c;

    always_comb begin
        txt_ra0 = i_a;
        txt_ra1 = i_a;
        sa_ra   = r_rank;
        rk_ra   = i_a;
        tmp_ra  = i_a;
        cnt_ra  = r_i;
        sa_we = 1'b0; sa_wa = r_pos; sa_wd = r_pos;
        rk_we = 1'b0; rk_wa = i_a; rk_wd = r_i;
        tmp_we = 1'b0; tmp_wa = i_a; tmp_wd = r_i;
        cnt_we = 1'b0; cnt_wa = r_i; cnt_wd = '0;
        lcp_we = 1'b0; lcp_wa = r_r; lcp_wd = r_j;
        unique case (i_cmd_bus.step)
            ST_INIT_WR: begin
                rk_we = 1'b1; rk_wd = VW'(r_txt0) + VW'(1);
                tmp_we = 1'b1;
            end
            ST_CS_CLR: cnt_we = 1'b1;
            ST_CS_CNT_B: cnt_ra = r_rk;
            ST_CS_CNT_C: begin
                cnt_we = 1'b1; cnt_wa = r_key; cnt_wd = r_cnt + VW'(1);
            end
            ST_CS_PRE_B: begin
                cnt_we = 1'b1; cnt_wd = r_sum + r_cnt;
            end
            ST_CS_PL_B: rk_ra = r_tmp[AW-1:0];
            ST_CS_PL_C: cnt_ra = r_rk;
            ST_CS_PL_D: begin
                sa_we = 1'b1; sa_wa = r_cnt[AW-1:0];
                cnt_we = 1'b1; cnt_wa = r_key; cnt_wd = r_cnt - VW'(1);
            end
            ST_D_FILL1: begin
                tmp_we = 1'b1; tmp_wd = VW'(n_w - r_w + i_w);
            end
            ST_D_FILL2A: sa_ra = i_a;
            ST_D_FILL2B: begin
                tmp_we = sa_gt; tmp_wa = AW'(r_q + VW'(1));
                tmp_wd = VW'(WW'(r_sa) - r_w);
            end
            ST_D_COPY_B: begin
                tmp_we = 1'b1; tmp_wd = r_rk;
            end
            ST_D_RR_A: sa_ra = i_a;
            ST_D_RR_B: tmp_ra = r_sa;
            ST_D_RR_C: tmp_ra = pw[AW-1:0];
            ST_D_RR_D: begin
                rk_we = 1'b1; rk_wa = r_pos; rk_wd = p_new;
            end
            ST_FIN_A: sa_ra = i_a;
            ST_FIN_B: begin
                rk_we = 1'b1; rk_wa = r_sa;
            end
            ST_LCP_B: begin
                sa_ra = AW'(r_rk - VW'(1));
                lcp_we = (r_rk <= VW'(1)); lcp_wa = r_rk[AW-1:0]; lcp_wd = '0;
            end
            ST_LCP_E: begin
                txt_ra0 = ij[AW-1:0];
                txt_ra1 = kj[AW-1:0];
            end
            ST_LCP_F: lcp_we = !o_stat.match;
            default: ;
        endcase
    end

    // Memories with registered read data
    always_ff @(posedge i_clk) begin
        if (txt_we) m_txt[txt_wa] <= txt_wd;
        r_txt0 <= m_txt[txt_ra0];
        r_txt1 <= m_txt[txt_ra1];
    end

    always_ff @(posedge i_clk) begin
        if (sa_we) m_sa[sa_wa] <= sa_wd;
        r_sa <= m_sa[sa_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rk_we) m_rk[rk_wa] <= rk_wd;
        r_rk <= m_rk[rk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tmp_we) m_tmp[tmp_wa] <= tmp_wd;
        r_tmp <= m_tmp[tmp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) m_cnt[cnt_wa] <= cnt_wd;
        r_cnt <= m_cnt[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lcp_we) m_lcp[lcp_wa] <= lcp_wd;
        r_lcp <= m_lcp[r_rank];
    end

    // Counters and working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd_bus.step)
            ST_IDLE: begin
                if (i_cmd_bus.accept) begin
                    r_i   <= VW'(1);
                    r_m   <= VW'(ALPHABET);
                    r_err <= rd_err;
                    r_rank <= AW'(i_rank_index);
                end
            end
            ST_INIT_WR: r_i <= o_stat.eq_n ? '0 : r_i + VW'(1);
            ST_CS_CLR:  r_i <= o_stat.eq_m ? VW'(1) : r_i + VW'(1);
            ST_CS_CNT_B: r_key <= r_rk;
            ST_CS_CNT_C: begin
                r_i   <= o_stat.eq_n ? '0 : r_i + VW'(1);
                r_sum <= '0;
            end
            ST_CS_PRE_B: begin
                r_sum <= r_sum + r_cnt;
                r_i   <= o_stat.eq_m ? n_v : r_i + VW'(1);
            end
            ST_CS_PL_B: r_pos <= r_tmp[AW-1:0];
            ST_CS_PL_C: r_key <= r_rk;
            ST_CS_PL_D: if (!o_stat.i_one) r_i <= r_i - VW'(1);
            ST_D_START: begin
                r_w <= WW'(1);
                r_p <= '0;
            end
            ST_D_FILL1: begin
                if (o_stat.eq_w) begin
                    r_i <= VW'(1);
                    r_q <= VW'(r_w);
                end else begin
                    r_i <= r_i + VW'(1);
                end
            end
            ST_D_FILL2B: begin
                if (sa_gt) r_q <= r_q + VW'(1);
                r_i <= o_stat.eq_n ? '0 : r_i + VW'(1);
            end
            ST_D_COPY_B: r_i <= o_stat.eq_n ? VW'(1) : r_i + VW'(1);
            ST_D_RR_B:   r_pos <= r_sa;
            ST_D_RR_C:   r_ka <= r_tmp;
            ST_D_RR_D: begin
                r_p  <= p_new;
                r_pa <= r_ka;
                r_pb <= kb;
                if (o_stat.eq_n) begin
                    r_i <= VW'(1);
                    r_m <= p_new;
                    r_w <= r_w << 1;
                end else begin
                    r_i <= r_i + VW'(1);
                end
            end
            ST_FIN_B: begin
                r_i <= o_stat.eq_n ? VW'(1) : r_i + VW'(1);
                r_j <= '0;
            end
            ST_LCP_B: begin
                r_r <= r_rk[AW-1:0];
                if (o_stat.le1) begin
                    r_j <= '0;
                    if (!o_stat.eq_n) r_i <= r_i + VW'(1);
                end else if (r_j != '0) begin
                    r_j <= r_j - AW'(1);
                end
            end
            ST_LCP_C: r_k <= r_sa;
            ST_LCP_E: r_inr <= inr;
            ST_LCP_F: begin
                if (o_stat.match) r_j <= r_j + AW'(1);
                else if (!o_stat.eq_n) r_i <= r_i + VW'(1);
            end
            default: ;
        endcase
    end

    // Length, build flag and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n      <= '0;
            r_built  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (is_load) begin
                if (r_built) begin
                    r_built <= 1'b0;
                    r_n     <= AW'(1);
                end else if (load) begin
                    r_n <= r_n + AW'(1);
                end
            end
            if (i_cmd_bus.step == ST_DONE) r_built <= 1'b1;
            if (i_cmd_bus.step == ST_RD_OUT && out_free) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.step == ST_RD_OUT && out_free) begin
            r_ss <= r_err ? '0 : SS_W'(r_sa);
            r_lp <= r_err ? '0 : LP_W'(r_lcp);
            r_st <= r_err;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_suffix_start = r_ss;
    assign o_lcp_prev     = r_lp;
    assign o_status       = r_st;

    assign o_stat.in_read  = i_cmd;
    assign o_stat.in_last  = i_last_char;
    assign o_stat.rd_err   = rd_err;
    assign o_stat.eq_n     = (r_i == n_v);
    assign o_stat.eq_m     = (r_i == r_m);
    assign o_stat.eq_w     = (i_w == r_w);
    assign o_stat.i_one    = (r_i == VW'(1));
    assign o_stat.go_on    = (r_p < n_v) && (r_w < n_w);
    assign o_stat.le1      = (r_rk <= VW'(1));
    assign o_stat.match    = r_inr && (r_txt0 == r_txt1);
    assign o_stat.out_free = out_free;

endmodule

>>> hw/rtl/suffix_array_lcp_builder.sv
// Suffix array and LCP builder. Letters are loaded one item each; the item
// marked last starts a build by prefix doubling with counting-sort passes,
// then a Kasai LCP pass. Read items return the 1-based start of the suffix
// at a given rank and its common prefix length with the suffix ranked just
// before it (0 for rank 1); a bad rank or no build gives zeros and status 1.
// A load after a build starts a new string; letters past MAX_LEN are
// dropped, codes of ALPHABET or more count as the last letter. A read of a
// bad rank skips the memory lookup, and any output stall holds a read. A
// build of n letters runs on one shared sequencer with memories that have
// registered read data: it seeds the ranks and counting-sorts them, then
// runs doubling rounds of width w, each a counting sort (m the bucket count)
// and a re-ranking, at most log2(n) + 1 rounds, then ranks the suffixes and
// runs the Kasai LCP pass; the input is held stalled meanwhile. The result
// register lets a finished result wait while the next item is taken.
module suffix_array_lcp_builder
    import salcp_pkg::*;
#(
    parameter int MAX_LEN  = 1024,
    parameter int ALPHABET = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_cmd,
    input  logic [CODE_W-1:0] i_char_code,
    input  logic              i_last_char,
    input  logic [RANK_W-1:0] i_rank_index,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [SS_W-1:0]   o_suffix_start,
    output logic [LP_W-1:0]   o_lcp_prev,
    output logic              o_status
);

    t_cmd  cmd_bus;
    t_stat stat_bus;

    // Take an item only while the sequencer is idle
    assign o_stall = !cmd_bus.idle;

    salcp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat_bus),
        .o_cmd   (cmd_bus)
    );

    salcp_dp #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_bus      (cmd_bus),
        .o_stat         (stat_bus),
        .i_cmd          (i_cmd),
        .i_char_code    (i_char_code),
        .i_last_char    (i_last_char),
        .i_rank_index   (i_rank_index),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_suffix_start (o_suffix_start),
        .o_lcp_prev     (o_lcp_prev),
        .o_status       (o_status)
    );

    // A build occupies the sequencer after its last letter
    a_build_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_cmd && i_last_char) |=> o_stall)
        else $error("build did not hold off input");

    // A read occupies the sequencer for its lookup
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_cmd) |=> o_stall)
        else $error("read did not hold off input");

    // Error results carry zero fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_suffix_start == '0 && o_lcp_prev == '0))
        else $error("error result with non-zero fields");

    // Good results point at a real position
    a_ok_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_status) |-> (o_suffix_start != '0))
        else $error("good result with zero start");

endmodule

>>> tb/sv/tb_suffix_array_lcp_builder.sv
// Testbench for suffix_array_lcp_builder: loads strings, triggers builds and reads ranks back.
// A small scoreboard class predicts every read result; depends on salcp_pkg.
`timescale 1ns / 100ps

module tb_suffix_array_lcp_builder;
    import salcp_pkg::*;

    localparam int MAX_LEN    = 1024;
    localparam int ALPHABET   = 26;
    localparam int WDOG_LIMIT = 1000000;

    localparam bit CMD_LOAD = 1'b0;
    localparam bit CMD_READ = 1'b1;

    // Predicts read results from the string loaded so far and holds the
    // expected results in order of acceptance.
    class lcp_scoreboard;
        typedef struct {
            logic [SS_W-1:0] start;
            logic [LP_W-1:0] lcp;
            logic            status;
        } t_read_result;

        logic [CODE_W-1:0] letters [1:MAX_LEN];
        int                order   [1:MAX_LEN];
        int                lcp_at  [1:MAX_LEN];
        int                length;
        bit                built;
        t_read_result      awaited [$];
        int                errors;

        function new();
            length = 0;
            built  = 0;
            errors = 0;
        endfunction

        // Shorter suffix sorts first when one is a prefix of the other.
        function bit suffix_less(int a, int b);
            int k;
            k = 0;
            while (a + k <= length && b + k <= length) begin
                if (letters[a+k] != letters[b+k])
                    return letters[a+k] < letters[b+k];
                k++;
            end
            return a + k > length;
        endfunction

        function void sort_suffixes();
            int i, j, cur, k;
            for (i = 1; i <= length; i++) begin
                cur = i;
                j   = i - 1;
                while (j >= 1 && suffix_less(cur, order[j])) begin
                    order[j+1] = order[j];
                    j--;
                end
                order[j+1] = cur;
            end
            lcp_at[1] = 0;
            for (i = 2; i <= length; i++) begin
                k = 0;
                while (order[i] + k <= length && order[i-1] + k <= length &&
                       letters[order[i]+k] == letters[order[i-1]+k])
                    k++;
                lcp_at[i] = k;
            end
            built = 1;
        endfunction

        function void note_item(bit cmd, logic [CODE_W-1:0] code, bit last,
                                logic [RANK_W-1:0] rank);
            t_read_result r;
            if (cmd == CMD_LOAD) begin
                if (built) begin
                    built  = 0;
                    length = 0;
                end
                if (code >= ALPHABET) code = CODE_W'(ALPHABET - 1);
                if (length < MAX_LEN) begin
                    length++;
                    letters[length] = code;
                end
                if (last) sort_suffixes();
            end else begin
                if (!built || rank == 0 || rank > length) begin
                    r.start  = '0;
                    r.lcp    = '0;
                    r.status = 1'b1;
                end else begin
                    r.start  = SS_W'(order[rank]);
                    r.lcp    = LP_W'(lcp_at[rank]);
                    r.status = 1'b0;
                end
                awaited.insert(awaited.size(), r);
            end
        endfunction

        function void check_result(logic [SS_W-1:0] start, logic [LP_W-1:0] lcp,
                                   logic status);
            t_read_result w;
            if (awaited.size() == 0) begin
                $display("%0t: result with none awaited: start %0d lcp %0d status %0d",
                         $time, start, lcp, status);
                errors++;
                return;
            end
            w = awaited.pop_front();
            if (start !== w.start) begin
                $display("%0t: suffix_start expected %0d actual %0d", $time, w.start, start);
                errors++;
            end
            if (lcp !== w.lcp) begin
                $display("%0t: lcp_prev expected %0d actual %0d", $time, w.lcp, lcp);
                errors++;
            end
            if (status !== w.status) begin
                $display("%0t: status expected %0d actual %0d", $time, w.status, status);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_cmd;
    logic [CODE_W-1:0] i_char_code;
    logic              i_last_char;
    logic [RANK_W-1:0] i_rank_index;
    logic              o_valid;
    logic              i_stall;
    logic [SS_W-1:0]   o_suffix_start;
    logic [LP_W-1:0]   o_lcp_prev;
    logic              o_status;

    lcp_scoreboard sb = new();

    int items_sent;
    bit send_calm;    // no gaps between input items
    bit recv_calm;    // never stall the output
    int stall_left;
    int quiet_cycles;

    suffix_array_lcp_builder #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_char_code    (i_char_code),
        .i_last_char    (i_last_char),
        .i_rank_index   (i_rank_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_suffix_start (o_suffix_start),
        .o_lcp_prev     (o_lcp_prev),
        .o_status       (o_status)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Output side: check each accepted result, then draw the next stall run.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_suffix_start, o_lcp_prev, o_status);
            stall_left = recv_calm ? 0 : $urandom_range(0, 5);
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog: count cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Drive one item and hold it until the block takes it. Valid stays high
    // into the next item when no gap is drawn.
    task automatic send_item(bit cmd, logic [CODE_W-1:0] code, bit last,
                             logic [RANK_W-1:0] rank);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_char_code  <= code;
        i_last_char  <= last;
        i_rank_index <= rank;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(cmd, code, last, rank);
        items_sent++;
    endtask

    task automatic load_letter(int code, bit last);
        send_item(CMD_LOAD, CODE_W'(code), last, RANK_W'($urandom_range(0, 2047)));
    endtask

    task automatic read_rank(int rank);
        send_item(CMD_READ, CODE_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                  RANK_W'(rank));
    endtask

    // Hold the input until every awaited result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited.size() != 0) @(posedge i_clk);
    endtask

    // One string of n letters from an alphabet of the given size, then
    // reads mostly in range with some bad ranks mixed in.
    task automatic string_and_reads(int n, int alpha, bit finish_it);
        int i, reads;
        for (i = 1; i <= n; i++)
            load_letter($urandom_range(0, alpha - 1), finish_it && i == n);
        reads = $urandom_range(1, 2 * n + 2);
        for (i = 0; i < reads; i++) begin
            if ($urandom_range(0, 99) < 85)
                read_rank($urandom_range(1, n));
            else
                read_rank($urandom_range(0, 2047));
        end
    endtask

    initial begin
        int i, kind, n, alpha;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_cmd        <= CMD_LOAD;
        i_char_code  <= '0;
        i_last_char  <= 1'b0;
        i_rank_index <= '0;
        items_sent   = 0;
        stall_left   = 0;
        quiet_cycles = 0;
        send_calm    = 0;
        recv_calm    = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: read before any build, out-of-alphabet code, bad ranks.
        read_rank(1);
        load_letter(25, 1'b0);
        load_letter(31, 1'b1);
        read_rank(0);
        read_rank(1);
        read_rank(2);
        read_rank(3);
        read_rank(2047);
        // Load after build restarts with a one-letter string.
        load_letter(0, 1'b1);
        read_rank(1);
        read_rank(2);
        // "banana": repeated overlaps give non-trivial LCPs.
        load_letter(1, 1'b0);
        load_letter(0, 1'b0);
        load_letter(13, 1'b0);
        load_letter(0, 1'b0);
        load_letter(13, 1'b0);
        load_letter(0, 1'b1);
        for (i = 1; i <= 6; i++) read_rank(i);
        // Load without a build mark leaves nothing readable.
        load_letter(3, 1'b0);
        read_rank(1);
        drain_results();

        // Full store: letters past the limit are dropped, the mark still builds.
        for (i = 1; i <= MAX_LEN + 6; i++)
            load_letter($urandom_range(0, ALPHABET - 1), i == MAX_LEN + 6);
        read_rank(1);
        read_rank(2);
        read_rank(MAX_LEN - 1);
        read_rank(MAX_LEN);
        read_rank(MAX_LEN + 1);
        read_rank(2047);
        for (i = 0; i < 20; i++) read_rank($urandom_range(1, MAX_LEN));

        // Random part.
        while (items_sent < 1400) begin
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: alpha = 2;
                1: alpha = 4;
                2: alpha = 26;
                default: alpha = 32;
            endcase
            n    = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 120)
                                                : $urandom_range(1, 24);
            kind = $urandom_range(0, 9);
            if (kind < 8)
                string_and_reads(n, alpha, 1'b1);
            else if (kind == 8)
                string_and_reads(n, alpha, 1'b0);
            else
                for (i = 0; i < 4; i++) read_rank($urandom_range(0, 2047));
            if ($urandom_range(0, 4) == 0) drain_results();
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/salcp_pkg.sv
hw/rtl/salcp_ctrl.sv
hw/rtl/salcp_dp.sv
hw/rtl/suffix_array_lcp_builder.sv
tb/sv/tb_suffix_array_lcp_builder.sv
